// ===== rtl/core/par_pkg.sv =====
// Package with the shared types, codes and constants of the panic alert reporter.
package par_pkg;

    // Event kind carried by one input word.
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_BUTTON = 2'd1,
        FUNC_MIC    = 2'd2,
        FUNC_ACCEL  = 2'd3
    } t_func;

    // Source of a panic as it appears on the result channel.
    typedef enum logic [1:0] {
        KIND_BUTTON = 2'd0,
        KIND_MIC    = 2'd1,
        KIND_ACCEL  = 2'd2
    } t_kind;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SUM_LIMIT = 2'd0;
    localparam logic [1:0] REG_CENTER    = 2'd1;
    localparam logic [1:0] REG_EXPIRY    = 2'd2;

    localparam logic [8:0] RST_SUM_LIMIT = 9'd80;
    localparam logic [7:0] RST_CENTER    = 8'h7F;
    localparam logic [7:0] RST_EXPIRY    = 8'd120;

    // Repeats of the same kind are dropped while the count is below this.
    localparam logic [7:0] REPEAT_WINDOW = 8'd10;
    // Position of the tick phase counter at which the next tick reports.
    localparam logic [3:0] PHASE_LAST    = 4'd9;

    // count*262/500 equals (count*SEC_RECIP) >> SEC_SHIFT for every 8-bit count.
    localparam logic [15:0] SEC_RECIP = 16'd34341;
    localparam int          SEC_SHIFT = 16;

    typedef struct packed {
        logic [8:0] sum_limit;
        logic [7:0] center;
        logic [7:0] expiry;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] seconds;
    } t_result;

endpackage

// ===== rtl/core/par_apb_regs.sv =====
// Configuration registers of the panic alert reporter behind an APB-style port.
module par_apb_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output par_pkg::t_cfg o_cfg
);
    import par_pkg::*;

    logic [8:0] r_sum_limit;
    logic [7:0] r_center;
    logic [7:0] r_expiry;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_limit <= RST_SUM_LIMIT;
            r_center    <= RST_CENTER;
            r_expiry    <= RST_EXPIRY;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SUM_LIMIT: r_sum_limit <= pwdata[8:0];
                REG_CENTER:    r_center    <= pwdata[7:0];
                REG_EXPIRY:    r_expiry    <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SUM_LIMIT: prdata = {23'd0, r_sum_limit};
            REG_CENTER:    prdata = {24'd0, r_center};
            REG_EXPIRY:    prdata = {24'd0, r_expiry};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{sum_limit: r_sum_limit, center: r_center, expiry: r_expiry};

endmodule

// ===== rtl/core/par_accel_detect.sv =====
// Accelerometer panic detector: sum of absolute axis deviations against the limit.
module par_accel_detect (
    input  logic          [7:0] i_axis_x,
    input  logic          [7:0] i_axis_y,
    input  logic          [7:0] i_axis_z,
    input  par_pkg::t_cfg       i_cfg,
    output logic                o_hit
);
    import par_pkg::*;

    logic [7:0] dev_x;
    logic [7:0] dev_y;
    logic [7:0] dev_z;
    logic [9:0] dev_sum;

    assign dev_x = (i_axis_x >= i_cfg.center) ? (i_axis_x - i_cfg.center)
                                              : (i_cfg.center - i_axis_x);
    assign dev_y = (i_axis_y >= i_cfg.center) ? (i_axis_y - i_cfg.center)
                                              : (i_cfg.center - i_axis_y);
    assign dev_z = (i_axis_z >= i_cfg.center) ? (i_axis_z - i_cfg.center)
                                              : (i_cfg.center - i_axis_z);

    assign dev_sum = {2'b00, dev_x} + {2'b00, dev_y} + {2'b00, dev_z};
    assign o_hit   = dev_sum > {1'b0, i_cfg.sum_limit};

endmodule

// ===== rtl/core/par_alert_core.sv =====
// Alert state of the panic alert reporter and the result of one event word.
module par_alert_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic          [1:0] i_func,
    input  logic                i_accel_hit,
    input  par_pkg::t_cfg       i_cfg,
    output par_pkg::t_result    o_result
);
    import par_pkg::*;

    logic        r_active;
    logic [7:0]  r_count;
    logic [3:0]  r_phase;
    t_kind       r_kind;
    logic        r_armed;

    logic        n_active;
    logic [7:0]  n_count;
    logic [3:0]  n_phase;
    t_kind       n_kind;
    logic        n_armed;

    logic        panic;
    t_kind       panic_kind;
    logic        tick_rep;
    logic        new_rep;
    logic [7:0]  cnt_inc;
    logic [23:0] sec_prod;

    assign cnt_inc  = r_count + 8'd1;
    assign sec_prod = {16'd0, cnt_inc} * {8'd0, SEC_RECIP};

    always_comb begin
        n_active   = r_active;
        n_count    = r_count;
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_armed    = r_armed;
        panic      = 1'b0;
        panic_kind = KIND_BUTTON;
        tick_rep   = 1'b0;
        new_rep    = 1'b0;
        if (i_fire) begin
            unique case (t_func'(i_func))
                FUNC_TICK: begin
                    if (r_active) begin
                        n_count  = cnt_inc;
                        n_phase  = (r_phase == PHASE_LAST) ? 4'd0 : r_phase + 4'd1;
                        tick_rep = (r_phase == PHASE_LAST);
                        if (cnt_inc >= i_cfg.expiry) begin
                            n_count  = 8'd0;
                            n_active = 1'b0;
                        end
                    end
                end
                FUNC_BUTTON: begin
                    panic      = 1'b1;
                    panic_kind = KIND_BUTTON;
                end
                FUNC_MIC: begin
                    // The first edge after reset only arms the microphone.
                    panic_kind = KIND_MIC;
                    if (!r_armed) begin
                        n_armed = 1'b1;
                    end else begin
                        panic = 1'b1;
                    end
                end
                FUNC_ACCEL: begin
                    panic      = i_accel_hit;
                    panic_kind = KIND_ACCEL;
                end
                default: ;
            endcase
        end
        if (panic && !(r_active && (r_kind == panic_kind) && (r_count < REPEAT_WINDOW))) begin
            n_active = 1'b1;
            n_kind   = panic_kind;
            n_count  = 8'd0;
            n_phase  = 4'd0;
            new_rep  = 1'b1;
        end
    end

    always_comb begin
        o_result.valid   = tick_rep || new_rep;
        o_result.kind    = new_rep ? panic_kind : r_kind;
        o_result.seconds = new_rep ? 8'd0 : sec_prod[SEC_SHIFT +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= 8'd0;
            r_phase  <= 4'd0;
            r_kind   <= KIND_BUTTON;
            r_armed  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_armed  <= n_armed;
        end
    end

endmodule

// ===== rtl/core/panic_alert_reporter_top.sv =====
// Top level of the panic alert reporter: input register, alert logic, result register.
//
// Each input word is one event: a timer tick, a button press, a microphone
// edge or an accelerometer sample (func selects which; the axis fields only
// matter for a sample). A panic produces a zero-second report, and while an
// alert is active every tenth tick produces a report of the elapsed seconds.
// Events that cause no report leave nothing on the result channel.
//
// A word accepted on the input channel lands in an input register; the
// alert logic then handles it and loads the result register once that
// register is free. One word is taken in every cycle while the input is
// not stalled. The alert state is a handful of flops and a small counter;
// the seconds come from one 8 by 16 bit constant multiply in that stage.
//
// When the receiver stalls, the result register holds its word. The input
// register still takes a word, and input stall rises only when that word is
// waiting behind a held result. Reset clears the alert, disarms the
// microphone, restores the register defaults and empties both stages.
// Registers sit at byte addresses 0, 4 and 8 of the configuration port and
// are to be written while the block is idle.
module panic_alert_reporter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_axis_x,
    input  logic [7:0]  i_axis_y,
    input  logic [7:0]  i_axis_z,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_alert_kind,
    output logic [7:0]  o_seconds_since,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import par_pkg::*;

    t_cfg       cfg;
    t_result    result;
    logic       accel_hit;
    logic       advance;
    logic       fire;
    logic       in_take;

    logic       r_in_valid;
    logic [1:0] r_func;
    logic [7:0] r_axis_x;
    logic [7:0] r_axis_y;
    logic [7:0] r_axis_z;

    logic       r_out_valid;
    logic [1:0] r_alert_kind;
    logic [7:0] r_seconds;

    // The processing stage moves whenever the result register is free or is
    // being emptied in this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    par_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    par_accel_detect u_accel (
        .i_axis_x (r_axis_x),
        .i_axis_y (r_axis_y),
        .i_axis_z (r_axis_z),
        .i_cfg    (cfg),
        .o_hit    (accel_hit)
    );

    par_alert_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_func      (r_func),
        .i_accel_hit (accel_hit),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= fire && result.valid;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func   <= i_func;
            r_axis_x <= i_axis_x;
            r_axis_y <= i_axis_y;
            r_axis_z <= i_axis_z;
        end
        if (advance) begin
            r_alert_kind <= result.kind;
            r_seconds    <= result.seconds;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_alert_kind    = r_alert_kind;
    assign o_seconds_since = r_seconds;

endmodule

// ===== rtl/core/par_checker.sv =====
// Port-level checker for the panic alert reporter and its bind to the top level.
module par_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_alert_kind,
    input logic [7:0] o_seconds_since
);

    // A held result word keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_alert_kind)
                                       && $stable(o_seconds_since))
        else $error("result word changed while stalled");

    // Input stall only comes from a result held by the receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // Reports name a real source and stay within the seconds range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alert_kind != 2'd3) && (o_seconds_since <= 8'd133))
        else $error("result word out of range");

    // Reset empties the result stage.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind panic_alert_reporter_top par_checker u_par_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_alert_kind    (o_alert_kind),
    .o_seconds_since (o_seconds_since)
);
